// File: rtl/bbra_pkg.sv
// Shared types and constants for the box blur row averaging unit.
// Used by every module under rtl; no dependencies of its own.
package bbra_pkg;

  localparam int NUM_CH    = 4;
  localparam int SUM_W     = 32;
  localparam int NARROW_W  = 16;
  localparam int WIN_W     = 16;
  localparam int RECIP_W   = 33;
  localparam int CH_W      = 8;
  localparam int CFG_IDX_W = 1;
  localparam int DIV_STEPS = RECIP_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [RECIP_W-1:0] RECIP_RESET = {1'b1, {(RECIP_W-1){1'b0}}};
  localparam logic [WIN_W-1:0]   WIN_RESET   = WIN_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_COUNT = 1'b0,
    REG_WIDE_MODE    = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_PIXEL = 1'b1
  } item_kind_t;

  typedef logic [NUM_CH-1:0][SUM_W-1:0] chan_vec_t;

  typedef struct packed {
    logic      valid;
    logic      last;
    chan_vec_t operand;
  } stage_t;

endpackage

// File: rtl/bbra_recip_div.sv
// Bit-serial restoring divider producing floor(2^32 / n) for the window count.
// Depends on bbra_pkg; one quotient bit per cycle, holds the result register.
module bbra_recip_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [bbra_pkg::WIN_W-1:0]    divisor,
  output logic                          busy,
  output logic [bbra_pkg::RECIP_W-1:0]  reciprocal
);
  import bbra_pkg::*;

  logic [WIN_W-1:0]     dvs;
  logic [WIN_W-1:0]     rem;
  logic [RECIP_W-1:0]   quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 bit_in;
  logic [WIN_W:0]       rem_sh;
  logic                 ge;
  logic [WIN_W:0]       diff;
  logic [WIN_W-1:0]     rem_next;
  logic [RECIP_W-1:0]   quo_next;

  assign bit_in   = (cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign rem_sh   = {rem, bit_in};
  assign ge       = (rem_sh >= {1'b0, dvs});
  assign diff     = rem_sh - {1'b0, dvs};
  assign rem_next = ge ? diff[WIN_W-1:0] : rem_sh[WIN_W-1:0];
  assign quo_next = {quo[RECIP_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      reciprocal <= RECIP_RESET;
      cnt        <= '0;
    end else if (start) begin
      busy <= 1'b1;
      dvs  <= (divisor == '0) ? WIN_W'(1) : divisor;
      rem  <= '0;
      quo  <= '0;
      cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
      cnt <= cnt - DIV_CNT_W'(1);
      if (cnt == '0) begin
        busy       <= 1'b0;
        reciprocal <= quo_next;
      end
    end
  end

endmodule

// File: rtl/bbra_accum.sv
// Running channel sums and the rounded-operand stage register.
// Depends on bbra_pkg; feeds bbra_scale through a stage_t struct.
module bbra_accum (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       take,
  input  logic                       stage_en,
  input  logic                       kind,
  input  bbra_pkg::chan_vec_t        enter,
  input  bbra_pkg::chan_vec_t        leave,
  input  logic                       row_end,
  input  logic                       wide_mode,
  input  logic [bbra_pkg::WIN_W-1:0] window_count,
  output bbra_pkg::stage_t           stage
);
  import bbra_pkg::*;

  chan_vec_t        sums;
  chan_vec_t        sums_next;
  chan_vec_t        operand_next;
  logic [SUM_W-1:0] mask;
  logic [SUM_W-1:0] half;

  assign mask = wide_mode ? '1 : SUM_W'({NARROW_W{1'b1}});
  assign half = SUM_W'(window_count >> 1);

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (kind == KIND_LOAD) begin
        sums_next[c] = enter[c] & mask;
      end else begin
        sums_next[c] = (sums[c] + enter[c] - leave[c]) & mask;
      end
      if (wide_mode) begin
        operand_next[c] = sums[c] + half;
      end else begin
        operand_next[c] = SUM_W'(sums[c][NARROW_W-1:0]) + half;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sums        <= '0;
      stage.valid <= 1'b0;
    end else begin
      if (take) begin
        sums <= sums_next;
      end
      if (stage_en) begin
        stage.valid <= take && (kind == KIND_PIXEL);
      end
    end
    if (stage_en && take) begin
      stage.last    <= row_end;
      stage.operand <= operand_next;
    end
  end

endmodule

// File: rtl/bbra_scale.sv
// Reciprocal multiply per channel and the packed-pixel output register.
// Depends on bbra_pkg; takes the stage_t struct from bbra_accum.
module bbra_scale (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  bbra_pkg::stage_t              stage,
  input  logic                          wide_mode,
  input  logic [bbra_pkg::RECIP_W-1:0]  reciprocal,
  output logic                          out_valid,
  output logic [bbra_pkg::SUM_W-1:0]    pixel,
  output logic                          last
);
  import bbra_pkg::*;

  localparam int PROD_W = SUM_W + RECIP_W;

  logic [SUM_W-1:0]               mul_a [NUM_CH];
  logic [RECIP_W-1:0]             mul_b;
  logic [PROD_W-1:0]              prod  [NUM_CH];
  logic [NUM_CH-1:0][CH_W-1:0]    pixel_next;

  assign mul_b = wide_mode ? reciprocal : RECIP_W'(reciprocal[RECIP_W-1:NARROW_W]);

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      mul_a[c] = wide_mode ? stage.operand[c]
                           : SUM_W'(stage.operand[c][NARROW_W:0]);
      prod[c]  = PROD_W'(mul_a[c]) * PROD_W'(mul_b);
      if (wide_mode) begin
        pixel_next[c] = prod[c][SUM_W +: CH_W];
      end else begin
        pixel_next[c] = prod[c][NARROW_W +: CH_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage.valid) begin
      pixel <= pixel_next;
      last  <= stage.last;
    end
  end

endmodule

// File: rtl/box_blur_row_average_unit.sv
// Box blur row averaging unit: running BGRA sums and reciprocal-scaled averages.
// Pixel items pass the accum stage and scale output registers; loads give no result.
// One item per cycle unless stalled; a waiting output with a full stage blocks the input.
// A window_count write starts a serial divide; input is held off until it ends.
// Reset (synchronous, rst high): sums zero, window count 1, narrow mode, reciprocal 2^32.
// Depends on bbra_pkg, bbra_recip_div, bbra_accum and bbra_scale.
module box_blur_row_average_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bbra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbra_pkg::WIN_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            kind,
  input  logic [bbra_pkg::SUM_W-1:0]      enter_b,
  input  logic [bbra_pkg::SUM_W-1:0]      enter_g,
  input  logic [bbra_pkg::SUM_W-1:0]      enter_r,
  input  logic [bbra_pkg::SUM_W-1:0]      enter_a,
  input  logic [bbra_pkg::SUM_W-1:0]      leave_b,
  input  logic [bbra_pkg::SUM_W-1:0]      leave_g,
  input  logic [bbra_pkg::SUM_W-1:0]      leave_r,
  input  logic [bbra_pkg::SUM_W-1:0]      leave_a,
  input  logic                            row_end,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bbra_pkg::SUM_W-1:0]      pixel,
  output logic                            last
);
  import bbra_pkg::*;

  logic               window_count_we;
  logic [WIN_W-1:0]   window_count;
  logic               wide_mode;
  logic               div_busy;
  logic [RECIP_W-1:0] reciprocal;
  logic               advance;
  logic               stage_en;
  logic               take;
  chan_vec_t          enter;
  chan_vec_t          leave;
  stage_t             stage;

  assign window_count_we = cfg_we && (cfg_index == REG_WINDOW_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= WIN_RESET;
      wide_mode    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_COUNT: window_count <= cfg_data;
        REG_WIDE_MODE:    wide_mode    <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  assign enter = {enter_a, enter_r, enter_g, enter_b};
  assign leave = {leave_a, leave_r, leave_g, leave_b};

  assign advance  = !out_valid || out_ready;
  assign stage_en = advance || !stage.valid;
  assign in_ready = stage_en && !div_busy && !window_count_we;
  assign take     = in_valid && in_ready;

  bbra_recip_div u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (window_count_we),
    .divisor    (cfg_data),
    .busy       (div_busy),
    .reciprocal (reciprocal)
  );

  bbra_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .stage_en     (stage_en),
    .kind         (kind),
    .enter        (enter),
    .leave        (leave),
    .row_end      (row_end),
    .wide_mode    (wide_mode),
    .window_count (window_count),
    .stage        (stage)
  );

  bbra_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .stage      (stage),
    .wide_mode  (wide_mode),
    .reciprocal (reciprocal),
    .out_valid  (out_valid),
    .pixel      (pixel),
    .last       (last)
  );

endmodule

// File: tb/box_blur_row_average_unit_test.sv
// Self-checking bench for box_blur_row_average_unit: streams load items and pixel rows,
// predicts every averaged pixel and compares each output transfer in order.
// Depends on bbra_pkg and the RTL under rtl.

typedef struct {
  bbra_pkg::item_kind_t kind;
  bbra_pkg::chan_vec_t  enter;
  bbra_pkg::chan_vec_t  leave;
  logic                 row_end;
} blur_item_t;

class blur_average_board;
  logic [31:0] sums [4];
  logic [15:0] win;
  logic        wide;
  logic [32:0] recip;
  logic [31:0] want_pixel [$];
  logic        want_last [$];
  int          errors;

  function new();
    for (int c = 0; c < 4; c++) sums[c] = '0;
    errors = 0;
    wide = 1'b0;
    set_window(16'd1);
  endfunction

  function void set_window(logic [15:0] n);
    logic [63:0] num;
    num = 64'h1_0000_0000;
    win = n;
    recip = 33'(num / ((n == 16'd0) ? 64'd1 : {48'd0, n}));
  endfunction

  function void write_reg(bbra_pkg::cfg_reg_t idx, logic [15:0] val);
    case (idx)
      bbra_pkg::REG_WINDOW_COUNT: set_window(val);
      bbra_pkg::REG_WIDE_MODE:    wide = val[0];
      default: ;
    endcase
  endfunction

  function logic [7:0] channel_mean(logic [31:0] sum);
    logic [15:0] half;
    logic [31:0] s32;
    logic [64:0] wprod;
    logic [16:0] s17;
    logic [16:0] r16;
    logic [33:0] nprod;
    half = win >> 1;
    if (wide) begin
      s32 = sum + {16'd0, half};
      wprod = {33'd0, s32} * {32'd0, recip};
      return wprod[39:32];
    end
    s17 = {1'b0, sum[15:0]} + {1'b0, half};
    r16 = recip[32:16];
    nprod = {17'd0, s17} * {17'd0, r16};
    return nprod[23:16];
  endfunction

  function logic [31:0] fit(logic [31:0] v);
    return wide ? v : {16'd0, v[15:0]};
  endfunction

  function void note_item(blur_item_t it);
    logic [31:0] pix;
    if (it.kind == bbra_pkg::KIND_LOAD) begin
      for (int c = 0; c < 4; c++) sums[c] = fit(it.enter[c]);
      return;
    end
    for (int c = 0; c < 4; c++) pix[8*c +: 8] = channel_mean(sums[c]);
    want_pixel.push_back(pix);
    want_last.push_back(it.row_end);
    for (int c = 0; c < 4; c++) sums[c] = fit(sums[c] + it.enter[c] - it.leave[c]);
  endfunction

  function void check_pixel(logic [31:0] pix, logic lst);
    logic [31:0] exp_pix;
    logic        exp_lst;
    if (want_pixel.size() == 0) begin
      $display("%0t: unexpected transfer, expected none, actual pixel %08h last %0b",
               $time, pix, lst);
      errors++;
      return;
    end
    exp_pix = want_pixel.pop_front();
    exp_lst = want_last.pop_front();
    if (pix !== exp_pix) begin
      $display("%0t: pixel mismatch, expected %08h, actual %08h", $time, exp_pix, pix);
      errors++;
    end
    if (lst !== exp_lst) begin
      $display("%0t: last mismatch, expected %0b, actual %0b", $time, exp_lst, lst);
      errors++;
    end
  endfunction

  function int pending();
    return want_pixel.size();
  endfunction
endclass

module box_blur_row_average_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bbra_pkg::*;

  localparam int SETTLE      = 8;
  localparam int STALL_LIMIT = 4000;
  localparam int IDLE_PCT    = 18;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WIN_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 kind;
  logic [SUM_W-1:0]     enter_b, enter_g, enter_r, enter_a;
  logic [SUM_W-1:0]     leave_b, leave_g, leave_r, leave_a;
  logic                 row_end;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SUM_W-1:0]     pixel;
  logic                 last;

  blur_average_board board = new();
  logic steady = 1'b0;
  int   quiet = 0;

  box_blur_row_average_unit u_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (steady) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_pixel(pixel, last);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("box_blur_row_average_unit_test: FAIL");
        $finish;
      end
    end
  end

  function automatic blur_item_t make_item(item_kind_t k, chan_vec_t e, chan_vec_t l,
                                           logic re);
    blur_item_t it;
    it.kind = k;
    it.enter = e;
    it.leave = l;
    it.row_end = re;
    return it;
  endfunction

  // realistic sums stay within what the window can hold; full ones use every bit
  function automatic logic [31:0] column_sum(bit full);
    int unsigned n;
    n = (board.win == 16'd0) ? 1 : board.win;
    return full ? $urandom : $urandom_range(0, 255 * n);
  endfunction

  function automatic chan_vec_t random_columns(bit full);
    chan_vec_t v;
    for (int c = 0; c < NUM_CH; c++) v[c] = column_sum(full);
    return v;
  endfunction

  task automatic send_item(blur_item_t it);
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    kind     <= it.kind;
    enter_b  <= it.enter[0];
    enter_g  <= it.enter[1];
    enter_r  <= it.enter[2];
    enter_a  <= it.enter[3];
    leave_b  <= it.leave[0];
    leave_g  <= it.leave[1];
    leave_r  <= it.leave[2];
    leave_a  <= it.leave[3];
    row_end  <= it.row_end;
    do @(posedge clk); while (!in_ready);
    board.note_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, val);
  endtask

  task automatic run_directed();
    send_item(make_item(KIND_PIXEL, '0, '0, 1'b0));
    send_item(make_item(KIND_LOAD, {4{32'hFFFF_FFFF}}, {4{32'hFFFF_FFFF}}, 1'b1));
    send_item(make_item(KIND_PIXEL, {4{32'hFFFF_FFFF}}, '0, 1'b1));
    send_item(make_item(KIND_PIXEL, '0, {4{32'hFFFF_FFFF}}, 1'b0));
    send_item(make_item(KIND_LOAD, '0, '0, 1'b0));
    // leaving more than entering wraps below zero
    send_item(make_item(KIND_PIXEL, {4{32'd1}}, {4{32'd2}}, 1'b0));
    send_item(make_item(KIND_PIXEL, '0, '0, 1'b1));
    send_item(make_item(KIND_LOAD, {32'h0000_01FF, 32'h0000_0100, 32'h0000_00FF, 32'h0},
                        '0, 1'b0));
    send_item(make_item(KIND_PIXEL, '0, '0, 1'b0));
    send_item(make_item(KIND_PIXEL, {32'h8000_0000, 32'h0001_0000, 32'h0000_FFFF,
                                     32'h1234_5678}, '0, 1'b0));
    send_item(make_item(KIND_PIXEL, '0, '0, 1'b1));
    send_item(make_item(KIND_LOAD, {4{32'hAAAA_AAAA}}, {4{32'h5555_5555}}, 1'b1));
    send_item(make_item(KIND_PIXEL, {4{32'h5555_5555}}, {4{32'hAAAA_AAAA}}, 1'b0));
    send_item(make_item(KIND_PIXEL, '0, '0, 1'b1));
  endtask

  task automatic run_phase(int n_items, bit with_pause);
    int sent;
    int row_len;
    bit full;
    bit paused;
    sent = 0;
    paused = 1'b0;
    // full sums push the rounding add past the top of the accumulator
    send_item(make_item(KIND_LOAD, {4{32'hFFFF_FFFF}}, '0, 1'b0));
    send_item(make_item(KIND_PIXEL, '0, '0, 1'b1));
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(make_item(item_kind_t'($urandom_range(0, 1)),
                            {$urandom, $urandom, $urandom, $urandom},
                            {$urandom, $urandom, $urandom, $urandom},
                            1'($urandom_range(0, 1))));
        sent++;
      end else begin
        full = ($urandom_range(0, 3) == 0);
        row_len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
        send_item(make_item(KIND_LOAD, random_columns(full), random_columns(full), 1'b0));
        for (int k = 0; k < row_len; k++) begin
          send_item(make_item(KIND_PIXEL, random_columns(full), random_columns(full),
                              k == row_len - 1));
        end
        sent += row_len + 1;
      end
      if (with_pause && !paused && sent >= n_items / 2) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    logic [15:0] win_tab [8];
    logic        wide_tab [8];
    win_tab  = '{16'd1, 16'd65535, 16'd0, 16'd3, 16'd255, 16'd65535, 16'd7, 16'd1};
    wide_tab = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
    win_tab[7]  = 16'($urandom_range(2, 65534));
    wide_tab[7] = 1'($urandom_range(0, 1));
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_WINDOW_COUNT;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    kind      <= KIND_LOAD;
    enter_b   <= '0;
    enter_g   <= '0;
    enter_r   <= '0;
    enter_a   <= '0;
    leave_b   <= '0;
    leave_g   <= '0;
    leave_r   <= '0;
    leave_a   <= '0;
    row_end   <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_WIDE_MODE, {15'd0, wide_tab[p]});
      write_reg(REG_WINDOW_COUNT, win_tab[p]);
      steady = (p == 3);
      run_phase(120, p == 1);
    end
    drain();
    repeat (SETTLE) @(posedge clk);
    if (board.errors == 0) begin
      $display("box_blur_row_average_unit_test: PASS");
    end else begin
      $display("box_blur_row_average_unit_test: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/bbra_pkg.sv
rtl/bbra_recip_div.sv
rtl/bbra_accum.sv
rtl/bbra_scale.sv
rtl/box_blur_row_average_unit.sv
tb/box_blur_row_average_unit_test.sv
